// ===== rtl/ogp_pkg.sv =====
// Shared constants and types for the occupancy grid projection block.
// No dependencies; used by ogp_div and occupancy_grid_projection.
package ogp_pkg;

    localparam int COORD_W   = 21;
    localparam int ORIGIN_W  = 22;
    localparam int SIDE_W    = 9;
    localparam int CNT_W     = 13;
    localparam int MAX_POINTS = 4096;
    localparam int PTR_W     = $clog2(MAX_POINTS);
    localparam int MAX_SIDE  = 256;
    localparam int GIDX_W    = $clog2(MAX_SIDE * MAX_SIDE);
    localparam int DIV_W     = 22;
    localparam int CS_W      = 16;

    typedef logic [1:0] t_op;
    typedef logic [2:0] t_status;
    typedef logic [1:0] t_cell;
    typedef logic [1:0] t_reg_idx;

    localparam t_op OP_ADD   = 2'd0;
    localparam t_op OP_BUILD = 2'd1;
    localparam t_op OP_READ  = 2'd2;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_EMPTY     = 3'd1;
    localparam t_status ST_TOO_LARGE = 3'd2;
    localparam t_status ST_FULL      = 3'd3;
    localparam t_status ST_OUTSIDE   = 3'd4;

    localparam t_cell CELL_UNKNOWN = 2'd0;
    localparam t_cell CELL_FREE    = 2'd1;
    localparam t_cell CELL_OCC     = 2'd2;

    localparam t_reg_idx REG_CELL_SIZE = 2'd0;
    localparam t_reg_idx REG_BAND_LOW  = 2'd1;
    localparam t_reg_idx REG_BAND_HIGH = 2'd2;

    // grid side = quotient + 3, so the quotient may not exceed this
    localparam logic [DIV_W-1:0] Q_LIMIT = DIV_W'(MAX_SIDE - 3);

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [CS_W-1:0]  divisor;
    } t_div_req;

endpackage

// ===== rtl/ogp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Uses ogp_pkg for the request struct and widths.
module ogp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ogp_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [ogp_pkg::DIV_W-1:0]   o_quot
);
    localparam int DW = ogp_pkg::DIV_W;
    localparam int VW = ogp_pkg::CS_W;
    localparam int CW = $clog2(DW);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem, r_dvs;
    logic [DW-1:0] r_quo;
    logic [VW:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out of the top of r_quo while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvs <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= fits ? VW'(trial - {1'b0, r_dvs}) : trial[VW-1:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== rtl/occupancy_grid_projection.sv =====
// Occupancy grid projection: point buffer, bounding box, grid build and cell read.
// Depends on ogp_pkg and ogp_div.
//
//  channel | dir | handshake              | payload
//  s_      | in  | i_s_tvalid/o_s_tready  | tuser opcode, tdata x,y,z,col,row
//  m_      | out | o_m_tvalid/i_m_tready  | tdata status..points_held
//  cfg     | in  | i_cfg_valid/o_cfg_ready| cfg_index, cfg_data
//
// Add point is answered directly; read cell goes through the registered grid memory read.
// Build divides the box width and height (ST_TOO_LARGE if a side is too big), clears the
// grid memory cell by cell, then for each buffered point reads the buffer, runs two
// divisions in the shared divider and does a grid read-modify-write.
// Reset is synchronous; no clearing pass, since a grid is cleared by each build.
// One item in flight; the next is taken once the waiting result is accepted on
// m_, which may be in the same cycle.
module occupancy_grid_projection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [79:0] i_s_tdata,   // point_x, point_y, point_z, cell_col, cell_row, pad
    input  logic [1:0]  i_s_tuser,   // opcode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [79:0] o_m_tdata,   // status, grid_width, grid_height, origin_x,
                                     // origin_y, cell_state, points_held
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [20:0] i_cfg_data
);
    localparam int CW = ogp_pkg::COORD_W;
    localparam int OW = ogp_pkg::ORIGIN_W;
    localparam int SW = ogp_pkg::SIDE_W;
    localparam int NW = ogp_pkg::CNT_W;
    localparam int PW = ogp_pkg::PTR_W;
    localparam int GW = ogp_pkg::GIDX_W;
    localparam int DW = ogp_pkg::DIV_W;
    localparam int AW = GW + 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIVW = 4'd1;
    localparam logic [3:0] S_DIVH = 4'd2;
    localparam logic [3:0] S_AREA = 4'd3;
    localparam logic [3:0] S_CLR  = 4'd4;
    localparam logic [3:0] S_PRD  = 4'd5;
    localparam logic [3:0] S_PDX  = 4'd6;
    localparam logic [3:0] S_PDXW = 4'd7;
    localparam logic [3:0] S_PDYW = 4'd8;
    localparam logic [3:0] S_PIDX = 4'd9;
    localparam logic [3:0] S_PRMW = 4'd10;
    localparam logic [3:0] S_RD   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [15:0] r_cs;
    logic signed [CW-1:0] r_blo, r_bhi;
    logic [NW-1:0] r_cnt, n_cnt;
    logic signed [CW-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [CW-1:0] n_minx, n_maxx, n_miny, n_maxy;
    logic [SW-1:0] r_bw, r_bh, n_bw, n_bh;
    logic signed [OW-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [DW-1:0] r_qw, n_qw, r_gx, n_gx;
    logic [AW-1:0] r_area, n_area, r_ptr, n_ptr;
    logic [NW-1:0] r_i, n_i;
    logic signed [OW:0] r_dy, n_dy;
    logic r_occ, n_occ;
    logic [7:0] r_gy, n_gy;
    logic [GW-1:0] r_gidx, n_gidx;
    logic r_m_tvalid, n_m_tvalid;
    logic [79:0] r_m_tdata;

    logic [3*CW-1:0] buf_mem [0:ogp_pkg::MAX_POINTS-1];
    logic [3*CW-1:0] r_buf_q;
    ogp_pkg::t_cell grid_mem [0:(1<<GW)-1];
    ogp_pkg::t_cell r_grid_q;

    logic buf_we, grid_we, grid_re, out_load, s_acc;
    logic [GW-1:0] grid_wa, grid_ra;
    ogp_pkg::t_cell grid_wd, o_cell;
    ogp_pkg::t_status o_status;
    ogp_pkg::t_div_req div_req;
    logic div_done;
    logic [DW-1:0] div_q;
    logic [15:0] cs_eff;

    logic [1:0] in_op;
    logic signed [CW-1:0] in_x, in_y, in_z, px, py, pz;
    logic [7:0] in_col, in_row;
    logic signed [OW:0] dx, dy;
    logic [DW-1:0] box_dx, box_dy;
    logic [AW-1:0] rd_addr, pj_addr;

    assign in_op  = i_s_tuser;
    assign in_x   = i_s_tdata[20:0];
    assign in_y   = i_s_tdata[41:21];
    assign in_z   = i_s_tdata[62:42];
    assign in_col = i_s_tdata[70:63];
    assign in_row = i_s_tdata[78:71];

    assign px = r_buf_q[CW-1:0];
    assign py = r_buf_q[2*CW-1:CW];
    assign pz = r_buf_q[3*CW-1:2*CW];

    assign cs_eff = (r_cs == 16'd0) ? 16'd1 : r_cs;
    assign o_s_tready = (r_state == S_IDLE) && (!r_m_tvalid || i_m_tready);
    assign s_acc = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign box_dx = DW'({r_maxx[CW-1], r_maxx} - {r_minx[CW-1], r_minx});
    assign box_dy = DW'({r_maxy[CW-1], r_maxy} - {r_miny[CW-1], r_miny});
    assign dx = {{2{px[CW-1]}}, px} - {r_ox[OW-1], r_ox};
    assign dy = {{2{py[CW-1]}}, py} - {r_oy[OW-1], r_oy};
    assign rd_addr = AW'({9'd0, in_row} * {8'd0, r_bw}) + AW'(in_col);
    assign pj_addr = AW'({9'd0, r_gy} * {8'd0, r_bw}) + AW'(r_gx[7:0]);

    ogp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_minx = r_minx; n_maxx = r_maxx; n_miny = r_miny; n_maxy = r_maxy;
        n_bw = r_bw; n_bh = r_bh; n_ox = r_ox; n_oy = r_oy;
        n_qw = r_qw; n_gx = r_gx; n_gy = r_gy; n_area = r_area; n_ptr = r_ptr;
        n_i = r_i; n_dy = r_dy; n_occ = r_occ; n_gidx = r_gidx;
        buf_we = 1'b0;
        grid_we = 1'b0; grid_wa = r_ptr[GW-1:0]; grid_wd = ogp_pkg::CELL_UNKNOWN;
        grid_re = 1'b0; grid_ra = pj_addr[GW-1:0];
        div_req.start = 1'b0; div_req.dividend = box_dx; div_req.divisor = cs_eff;
        out_load = 1'b0;
        o_status = ogp_pkg::ST_OK;
        o_cell = ogp_pkg::CELL_UNKNOWN;
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        ogp_pkg::OP_ADD: begin
                            out_load = 1'b1;
                            if (r_cnt == NW'(ogp_pkg::MAX_POINTS)) begin
                                o_status = ogp_pkg::ST_FULL;
                            end else begin
                                buf_we = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                if (in_x < r_minx) n_minx = in_x;
                                if (in_x > r_maxx) n_maxx = in_x;
                                if (in_y < r_miny) n_miny = in_y;
                                if (in_y > r_maxy) n_maxy = in_y;
                            end
                        end
                        ogp_pkg::OP_BUILD: begin
                            if (r_cnt == '0) begin
                                out_load = 1'b1;
                                o_status = ogp_pkg::ST_EMPTY;
                            end else begin
                                div_req.start = 1'b1;
                                n_state = S_DIVW;
                            end
                        end
                        ogp_pkg::OP_READ: begin
                            if ({1'b0, in_col} >= r_bw || {1'b0, in_row} >= r_bh) begin
                                out_load = 1'b1;
                                o_status = ogp_pkg::ST_OUTSIDE;
                            end else begin
                                grid_re = 1'b1;
                                grid_ra = rd_addr[GW-1:0];
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_DIVW: begin
                if (div_done) begin
                    n_qw = div_q;
                    div_req.start = 1'b1;
                    div_req.dividend = box_dy;
                    n_state = S_DIVH;
                end
            end
            S_DIVH: begin
                if (div_done) begin
                    if (r_qw > ogp_pkg::Q_LIMIT || div_q > ogp_pkg::Q_LIMIT) begin
                        out_load = 1'b1;
                        o_status = ogp_pkg::ST_TOO_LARGE;
                        n_state = S_IDLE;
                    end else begin
                        n_bw = SW'(r_qw[7:0]) + SW'(3);
                        n_bh = SW'(div_q[7:0]) + SW'(3);
                        n_ox = {r_minx[CW-1], r_minx} - OW'(cs_eff);
                        n_oy = {r_miny[CW-1], r_miny} - OW'(cs_eff);
                        n_state = S_AREA;
                    end
                end
            end
            S_AREA: begin
                n_area = AW'(r_bw * r_bh);
                n_ptr = '0;
                n_state = S_CLR;
            end
            S_CLR: begin
                grid_we = 1'b1;
                n_ptr = r_ptr + 1'b1;
                if (n_ptr == r_area) begin
                    n_i = '0;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                // buffer is read at r_i every cycle; data lands in S_PDX
                if (r_i == r_cnt) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PDX;
                end
            end
            S_PDX: begin
                n_dy = dy;
                n_occ = (pz >= r_blo) && (pz <= r_bhi);
                if (dx[OW] || dy[OW]) begin
                    n_i = r_i + 1'b1;
                    n_state = S_PRD;
                end else begin
                    div_req.start = 1'b1;
                    div_req.dividend = dx[DW-1:0];
                    n_state = S_PDXW;
                end
            end
            S_PDXW: begin
                if (div_done) begin
                    n_gx = div_q;
                    div_req.start = 1'b1;
                    div_req.dividend = r_dy[DW-1:0];
                    n_state = S_PDYW;
                end
            end
            S_PDYW: begin
                if (div_done) begin
                    if (r_gx >= DW'(r_bw) || div_q >= DW'(r_bh)) begin
                        n_i = r_i + 1'b1;
                        n_state = S_PRD;
                    end else begin
                        n_gy = div_q[7:0];
                        n_state = S_PIDX;
                    end
                end
            end
            S_PIDX: begin
                grid_re = 1'b1;
                n_gidx = pj_addr[GW-1:0];
                n_state = S_PRMW;
            end
            S_PRMW: begin
                grid_wa = r_gidx;
                if (r_occ) begin
                    grid_we = 1'b1;
                    grid_wd = ogp_pkg::CELL_OCC;
                end else if (r_grid_q != ogp_pkg::CELL_OCC) begin
                    grid_we = 1'b1;
                    grid_wd = ogp_pkg::CELL_FREE;
                end
                n_i = r_i + 1'b1;
                n_state = S_PRD;
            end
            S_RD: begin
                out_load = 1'b1;
                o_cell = r_grid_q;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_m_tvalid = out_load ? 1'b1 : (i_m_tready ? 1'b0 : r_m_tvalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cs  <= 16'd50;
            r_blo <= CW'(100);
            r_bhi <= CW'(2000);
            r_cnt <= '0;
            r_minx <= {1'b0, {(CW-1){1'b1}}};
            r_miny <= {1'b0, {(CW-1){1'b1}}};
            r_maxx <= {1'b1, {(CW-1){1'b0}}};
            r_maxy <= {1'b1, {(CW-1){1'b0}}};
            r_bw <= '0; r_bh <= '0; r_ox <= '0; r_oy <= '0;
            r_i <= '0; r_ptr <= '0; r_area <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_minx <= n_minx; r_maxx <= n_maxx; r_miny <= n_miny; r_maxy <= n_maxy;
            r_bw <= n_bw; r_bh <= n_bh; r_ox <= n_ox; r_oy <= n_oy;
            r_i <= n_i; r_ptr <= n_ptr; r_area <= n_area;
            r_m_tvalid <= n_m_tvalid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ogp_pkg::REG_CELL_SIZE: r_cs  <= i_cfg_data[15:0];
                    ogp_pkg::REG_BAND_LOW:  r_blo <= i_cfg_data;
                    ogp_pkg::REG_BAND_HIGH: r_bhi <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qw <= n_qw; r_gx <= n_gx; r_gy <= n_gy;
        r_dy <= n_dy; r_occ <= n_occ; r_gidx <= n_gidx;
        if (out_load) begin
            r_m_tdata <= {n_cnt, o_cell, n_oy, n_ox, n_bh, n_bw, o_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            buf_mem[r_cnt[PW-1:0]] <= {in_z, in_y, in_x};
        end
        r_buf_q <= buf_mem[r_i[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (grid_we) begin
            grid_mem[grid_wa] <= grid_wd;
        end
        if (grid_re) begin
            r_grid_q <= grid_mem[grid_ra];
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(ogp_pkg::MAX_POINTS))
        else $error("point count beyond buffer depth");
    a_grid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !grid_we)
        else $error("grid written while idle");
    a_clr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLR |-> r_ptr < r_area)
        else $error("clear sweep past grid area");
    a_side_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bw == '0) == (r_bh == '0))
        else $error("grid built with one zero side");
endmodule
